// File: design/epoch_seconds_to_calendar_top_assert.svh
// Assertion macros shared by the calendar converter.
// Both expect clk and rst_n in the scope of the module that uses them.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define E2C_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define E2C_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/e2c_pkg.sv
`timescale 1ns / 1ps

package e2c_pkg;

    localparam int ACC_W  = 31;
    localparam int QUO_W  = 15;
    localparam int TOD_W  = 17;
    localparam int PROD_W = 49;

    typedef logic [3:0] op_t;
    typedef logic [1:0] cond_t;
    typedef logic [1:0] dsel_t;
    typedef logic [3:0] pc_t;

    localparam op_t OP_DIV       = 4'd0;
    localparam op_t OP_SAVE_TOD  = 4'd1;
    localparam op_t OP_QUAD      = 4'd2;
    localparam op_t OP_YEAR      = 4'd3;
    localparam op_t OP_SAVE_YDAY = 4'd4;
    localparam op_t OP_SAVE_WD   = 4'd5;
    localparam op_t OP_MONTH     = 4'd6;
    localparam op_t OP_SAVE_MDAY = 4'd7;
    localparam op_t OP_SAVE_HOUR = 4'd8;
    localparam op_t OP_FINISH    = 4'd9;

    localparam cond_t COND_NONE = 2'd0;
    localparam cond_t COND_GE   = 2'd2;

    localparam dsel_t DSEL_DAY  = 2'd0;
    localparam dsel_t DSEL_WEEK = 2'd1;
    localparam dsel_t DSEL_HOUR = 2'd2;
    localparam dsel_t DSEL_MIN  = 2'd3;

    // reciprocals for the odd part of each divisor, exact over the operand range
    localparam logic [PROD_W-1:0] DAY_RECIP  = 49'd25451659;
    localparam logic [PROD_W-1:0] WEEK_RECIP = 49'd586;
    localparam logic [PROD_W-1:0] HOUR_RECIP = 49'd9321;
    localparam logic [PROD_W-1:0] MIN_RECIP  = 49'd1093;

    localparam logic [ACC_W-1:0] DAY_SECS  = 31'd86400;
    localparam logic [ACC_W-1:0] HOUR_SECS = 31'd3600;
    localparam logic [ACC_W-1:0] MIN_SECS  = 31'd60;
    localparam logic [ACC_W-1:0] WEEK_DAYS = 31'd7;
    localparam logic [ACC_W-1:0] QUAD_DAYS = 31'd1461;
    localparam logic [ACC_W-1:0] YEAR_DAYS = 31'd365;
    localparam logic [ACC_W-1:0] LEAP_DAYS = 31'd366;

    localparam logic [10:0] BASE_YEAR = 11'd1970;
    localparam logic [2:0]  THURSDAY  = 3'd4;
    localparam logic [2:0]  QUAD_WD   = 3'd5;
    localparam logic [2:0]  YEAR_WD   = 3'd1;
    localparam logic [2:0]  LEAP_WD   = 3'd2;
    localparam logic [3:0]  FEBRUARY  = 4'd1;
    localparam logic [3:0]  DECEMBER  = 4'd11;

    localparam pc_t LAST_PC = 4'd12;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
        cond_t cond;
        pc_t   tgt;
        logic  last;
    } uword_t;

    typedef struct packed {
        logic ge;
    } dp_stat_t;

    function automatic logic [ACC_W-1:0] div_const(input dsel_t sel);
        logic [ACC_W-1:0] v;
        begin
            unique case (sel)
                DSEL_DAY:  v = DAY_SECS;
                DSEL_WEEK: v = WEEK_DAYS;
                DSEL_HOUR: v = HOUR_SECS;
                DSEL_MIN:  v = MIN_SECS;
                default:   v = DAY_SECS;
            endcase
            return v;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        begin
            case (m)
                4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: v = 5'd31;
                4'd3, 4'd5, 4'd8, 4'd10:                   v = 5'd30;
                FEBRUARY:                                  v = leap ? 5'd29 : 5'd28;
                default:                                   v = 5'd31;
            endcase
            return v;
        end
    endfunction

    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 4'd7)
                s = s - 4'd7;
            return s[2:0];
        end
    endfunction

    function automatic uword_t mk(input op_t op, input dsel_t dsel,
                                  input cond_t cond, input pc_t tgt, input logic last);
        uword_t w;
        begin
            w.op   = op;
            w.dsel = dsel;
            w.cond = cond;
            w.tgt  = tgt;
            w.last = last;
            return w;
        end
    endfunction

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        begin
            unique case (pc)
                4'd0:  w = mk(OP_DIV,       DSEL_DAY,  COND_NONE, 4'd0, 1'b0);
                4'd1:  w = mk(OP_SAVE_TOD,  DSEL_DAY,  COND_NONE, 4'd0, 1'b0);
                4'd2:  w = mk(OP_QUAD,      DSEL_DAY,  COND_GE,   4'd2, 1'b0);
                4'd3:  w = mk(OP_YEAR,      DSEL_DAY,  COND_GE,   4'd3, 1'b0);
                4'd4:  w = mk(OP_SAVE_YDAY, DSEL_WEEK, COND_NONE, 4'd0, 1'b0);
                4'd5:  w = mk(OP_DIV,       DSEL_WEEK, COND_NONE, 4'd0, 1'b0);
                4'd6:  w = mk(OP_SAVE_WD,   DSEL_WEEK, COND_NONE, 4'd0, 1'b0);
                4'd7:  w = mk(OP_MONTH,     DSEL_DAY,  COND_GE,   4'd7, 1'b0);
                4'd8:  w = mk(OP_SAVE_MDAY, DSEL_HOUR, COND_NONE, 4'd0, 1'b0);
                4'd9:  w = mk(OP_DIV,       DSEL_HOUR, COND_NONE, 4'd0, 1'b0);
                4'd10: w = mk(OP_SAVE_HOUR, DSEL_HOUR, COND_NONE, 4'd0, 1'b0);
                4'd11: w = mk(OP_DIV,       DSEL_MIN,  COND_NONE, 4'd0, 1'b0);
                default: w = mk(OP_FINISH,  DSEL_MIN,  COND_NONE, 4'd0, 1'b1);
            endcase
            return w;
        end
    endfunction

endpackage

// File: design/e2c_seq.sv
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_top_assert.svh"

module e2c_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  e2c_pkg::dp_stat_t stat,
    output e2c_pkg::uword_t   uw,
    output logic              run,
    output logic              done
);

    e2c_pkg::pc_t pc_reg;
    e2c_pkg::pc_t pc_next;
    logic         run_reg;
    logic         run_next;
    logic         done_reg;
    logic         done_next;
    logic         take;

    assign uw = e2c_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (uw.cond)
            e2c_pkg::COND_GE:  take = stat.ge;
            default:           take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (!run_reg)
        begin
            if (start)
            begin
                run_next = 1'b1;
                pc_next  = '0;
            end
        end
        else if (uw.last)
        begin
            run_next  = 1'b0;
            done_next = 1'b1;
        end
        else if (take)
        begin
            pc_next = uw.tgt;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign run  = run_reg;
    assign done = done_reg;

    `E2C_AST_SAME(a_done_idle, done_reg, !run_reg, "done strobe while still running")
    `E2C_AST_NEXT(a_start_run, start && !run_reg, run_reg && pc_reg == '0, "start not taken")
    `E2C_AST_SAME(a_pc_range, run_reg, pc_reg <= e2c_pkg::LAST_PC, "step counter out of program")
    `E2C_AST_NEXT(a_last_done, run_reg && uw.last, done_reg && !run_reg, "last step gave no strobe")

endmodule

// File: design/e2c_dp.sv
`timescale 1ns / 1ps

module e2c_dp
(
    input  logic                          clk,
    input  logic                          load,
    input  logic                          run,
    input  logic [e2c_pkg::ACC_W-1:0]     secs,
    input  e2c_pkg::uword_t               uw,
    output e2c_pkg::dp_stat_t             stat,
    output logic [10:0]                   year,
    output logic [3:0]                    month_index,
    output logic [4:0]                    day_of_month,
    output logic [4:0]                    hour,
    output logic [5:0]                    minute,
    output logic [5:0]                    second,
    output logic [2:0]                    weekday,
    output logic [8:0]                    day_of_year
);

    logic [e2c_pkg::ACC_W-1:0] acc_reg;
    logic [e2c_pkg::QUO_W-1:0] quo_reg;
    logic [e2c_pkg::TOD_W-1:0] tod_reg;
    logic [10:0]               year_reg;
    logic [3:0]                month_reg;
    logic [4:0]                mday_reg;
    logic [4:0]                hour_reg;
    logic [5:0]                minute_reg;
    logic [5:0]                second_reg;
    logic [2:0]                wd_reg;
    logic [8:0]                yday_reg;

    logic                       leap;
    logic [4:0]                 mlen;
    logic [e2c_pkg::ACC_W-1:0]  opnd;
    logic [e2c_pkg::ACC_W-1:0]  diff;
    logic                       ge;
    logic [e2c_pkg::PROD_W-1:0] qmul;
    logic [e2c_pkg::QUO_W-1:0]  quo_new;
    logic [e2c_pkg::ACC_W-1:0]  qprod;
    logic [e2c_pkg::ACC_W-1:0]  rem;

    assign leap = (year_reg[1:0] == 2'b00);
    assign mlen = e2c_pkg::month_len(month_reg, leap);

    always_comb
    begin
        case (uw.op)
            e2c_pkg::OP_QUAD:  opnd = e2c_pkg::QUAD_DAYS;
            e2c_pkg::OP_YEAR:  opnd = leap ? e2c_pkg::LEAP_DAYS : e2c_pkg::YEAR_DAYS;
            e2c_pkg::OP_MONTH: opnd = {{(e2c_pkg::ACC_W-5){1'b0}}, mlen};
            default:           opnd = '0;
        endcase
    end

    assign diff = acc_reg - opnd;
    assign ge   = (acc_reg >= opnd)
                  && !(uw.op == e2c_pkg::OP_MONTH && month_reg == e2c_pkg::DECEMBER);

    assign stat.ge = ge;

    // strip the power of two, then multiply by the reciprocal of the odd part
    always_comb
    begin
        unique case (uw.dsel)
            e2c_pkg::DSEL_DAY:
            begin
                qmul    = {{(e2c_pkg::PROD_W-24){1'b0}}, acc_reg[30:7]} * e2c_pkg::DAY_RECIP;
                quo_new = qmul[48:34];
            end
            e2c_pkg::DSEL_WEEK:
            begin
                qmul    = {{(e2c_pkg::PROD_W-9){1'b0}}, acc_reg[8:0]} * e2c_pkg::WEEK_RECIP;
                quo_new = {{(e2c_pkg::QUO_W-7){1'b0}}, qmul[18:12]};
            end
            e2c_pkg::DSEL_HOUR:
            begin
                qmul    = {{(e2c_pkg::PROD_W-13){1'b0}}, acc_reg[16:4]} * e2c_pkg::HOUR_RECIP;
                quo_new = {{(e2c_pkg::QUO_W-6){1'b0}}, qmul[26:21]};
            end
            e2c_pkg::DSEL_MIN:
            begin
                qmul    = {{(e2c_pkg::PROD_W-10){1'b0}}, acc_reg[11:2]} * e2c_pkg::MIN_RECIP;
                quo_new = {{(e2c_pkg::QUO_W-7){1'b0}}, qmul[20:14]};
            end
            default:
            begin
                qmul    = '0;
                quo_new = '0;
            end
        endcase
    end

    assign qprod = {{(e2c_pkg::ACC_W-e2c_pkg::QUO_W){1'b0}}, quo_reg}
                   * e2c_pkg::div_const(uw.dsel);
    assign rem   = acc_reg - qprod;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg   <= secs;
            quo_reg   <= '0;
            year_reg  <= e2c_pkg::BASE_YEAR;
            month_reg <= '0;
            wd_reg    <= e2c_pkg::THURSDAY;
        end
        else if (run)
        begin
            case (uw.op)
                e2c_pkg::OP_DIV:
                begin
                    quo_reg <= quo_new;
                end
                e2c_pkg::OP_SAVE_TOD:
                begin
                    tod_reg <= rem[e2c_pkg::TOD_W-1:0];
                    acc_reg <= {{(e2c_pkg::ACC_W-e2c_pkg::QUO_W){1'b0}}, quo_reg};
                end
                e2c_pkg::OP_QUAD:
                begin
                    if (ge)
                    begin
                        acc_reg  <= diff;
                        year_reg <= year_reg + 11'd4;
                        wd_reg   <= e2c_pkg::add_mod7(wd_reg, e2c_pkg::QUAD_WD);
                    end
                end
                e2c_pkg::OP_YEAR:
                begin
                    if (ge)
                    begin
                        acc_reg  <= diff;
                        year_reg <= year_reg + 11'd1;
                        wd_reg   <= e2c_pkg::add_mod7(wd_reg,
                                        leap ? e2c_pkg::LEAP_WD : e2c_pkg::YEAR_WD);
                    end
                end
                e2c_pkg::OP_SAVE_YDAY:
                begin
                    yday_reg <= acc_reg[8:0];
                    acc_reg  <= acc_reg + {{(e2c_pkg::ACC_W-3){1'b0}}, wd_reg};
                end
                e2c_pkg::OP_SAVE_WD:
                begin
                    wd_reg  <= rem[2:0];
                    acc_reg <= {{(e2c_pkg::ACC_W-9){1'b0}}, yday_reg};
                end
                e2c_pkg::OP_MONTH:
                begin
                    if (ge)
                    begin
                        acc_reg   <= diff;
                        month_reg <= month_reg + 4'd1;
                    end
                end
                e2c_pkg::OP_SAVE_MDAY:
                begin
                    mday_reg <= acc_reg[4:0] + 5'd1;
                    acc_reg  <= {{(e2c_pkg::ACC_W-e2c_pkg::TOD_W){1'b0}}, tod_reg};
                end
                e2c_pkg::OP_SAVE_HOUR:
                begin
                    hour_reg <= quo_reg[4:0];
                    acc_reg  <= rem;
                end
                e2c_pkg::OP_FINISH:
                begin
                    minute_reg <= quo_reg[5:0];
                    second_reg <= rem[5:0];
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign year         = year_reg;
    assign month_index  = month_reg;
    assign day_of_month = mday_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign weekday      = wd_reg;
    assign day_of_year  = yday_reg;

endmodule

// File: design/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps

// Converts a seconds count since midnight 1 Jan 1970 into calendar year, month,
// day of month, hour, minute, second, weekday and day of year, using the
// every-fourth-year leap rule. Pulse start while busy is low; the word is taken
// on that edge and busy rises. A small microcode program then runs one step per
// clock: a reciprocal multiply for the divide by 86400, a peel of four-year
// blocks and then of single years, a weekday remainder, a month peel, and
// divides by 3600 and 60.
// The result ports are valid for the single cycle in which done is high, and
// the receiver must take them then: there is no way to hold them off. The time
// until done rises depends on how often the year-block, year and month peel
// loops repeat; busy falls in the same cycle as done rises, so the next start can
// be taken while done is shown.
module epoch_seconds_to_calendar_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] epoch_seconds,
    output logic        done,
    output logic [10:0] year,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year
);

    e2c_pkg::uword_t   uw;
    e2c_pkg::dp_stat_t stat;
    logic              run;
    logic              load;

    assign busy = run;
    assign load = start && !run;

    e2c_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .uw    (uw),
        .run   (run),
        .done  (done)
    );

    e2c_dp u_dp
    (
        .clk          (clk),
        .load         (load),
        .run          (run),
        .secs         (epoch_seconds),
        .uw           (uw),
        .stat         (stat),
        .year         (year),
        .month_index  (month_index),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .weekday      (weekday),
        .day_of_year  (day_of_year)
    );

endmodule
